@@ hdl/frt_pkg.sv @@
// Shared types and constants for the flow record table.
`default_nettype none

package frt_pkg;

  // Fixed field widths of a request and a result.
  localparam int KEY_IN_W = 64;
  localparam int BYTES_W  = 32;
  localparam int PKTS_W   = 32;
  localparam int FLAGS_W  = 8;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;

  // Request type codes.
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;  // clear the valid bit of one slot
    logic accept;    // capture a request and restart the scan
    logic scan_en;   // scan the table for a key match and a free slot
    logic commit;    // write the table and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // the slot being cleared is the last one
    logic scan_done;   // a match was found or every slot was compared
    logic out_free;    // the result register can take a new transaction
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/frt_ctrl.sv @@
// Controller state machine of the flow record table.
`default_nettype none

module frt_ctrl
  import frt_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  input  sts_t sts,
  output cmd_t cmd,
  output logic idle
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state: clear pass after reset, then accept, scan and commit.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands decoded from the current state.
  always_comb begin
    cmd.clear_en = (state_r == S_CLEAR);
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.scan_en  = (state_r == S_SCAN);
    cmd.commit   = (state_r == S_COMMIT) && sts.out_free;
  end

  assign idle = (state_r == S_IDLE);

endmodule

`default_nettype wire

@@ hdl/frt_dpath.sv @@
// Datapath of the flow record table: slot memories, scan logic and result register.
`default_nettype none

module frt_dpath
  import frt_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  wire                  in_req_type,
  input  wire  [KEY_IN_W-1:0]  in_flow_key,
  input  wire  [BYTES_W-1:0]   in_add_bytes,
  input  wire  [PKTS_W-1:0]    in_add_packets,
  input  wire  [FLAGS_W-1:0]   in_tcp_flag_bits,
  input  wire  [TIME_W-1:0]    in_seen_time,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [BYTES_W-1:0]   out_total_bytes,
  output logic [PKTS_W-1:0]    out_total_packets,
  output logic [FLAGS_W-1:0]   out_flags_seen,
  output logic [TIME_W-1:0]    out_last_seen
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY - 1);

  // Slot memories.
  logic                mem_valid [CAPACITY];
  logic [KEY_BITS-1:0] mem_key   [CAPACITY];
  logic [BYTES_W-1:0]  mem_bytes [CAPACITY];
  logic [PKTS_W-1:0]   mem_pkts  [CAPACITY];
  logic [FLAGS_W-1:0]  mem_flags [CAPACITY];
  logic [TIME_W-1:0]   mem_last  [CAPACITY];

  // Registered read data.
  logic                rd_valid_q;
  logic [KEY_BITS-1:0] rd_key_q;
  logic [BYTES_W-1:0]  rd_bytes_q;
  logic [PKTS_W-1:0]   rd_pkts_q;
  logic [FLAGS_W-1:0]  rd_flags_q;
  logic [TIME_W-1:0]   rd_last_q;

  // Captured request.
  logic                req_type_r;
  logic [KEY_BITS-1:0] req_key_r;
  logic [BYTES_W-1:0]  req_bytes_r;
  logic [PKTS_W-1:0]   req_pkts_r;
  logic [FLAGS_W-1:0]  req_flags_r;
  logic [TIME_W-1:0]   req_time_r;

  // Scan state.
  logic [CNT_W-1:0]    cnt_r,        cnt_nxt;
  logic                cmp_vld_r,    cmp_vld_nxt;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                hit_r,        hit_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic [BYTES_W-1:0]  hit_bytes_r;
  logic [PKTS_W-1:0]   hit_pkts_r;
  logic [FLAGS_W-1:0]  hit_flags_r;
  logic [TIME_W-1:0]   hit_last_r;

  logic issue;
  logic hit_now;
  logic free_now;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r;
  logic [BYTES_W-1:0]  out_bytes_r;
  logic [PKTS_W-1:0]   out_pkts_r;
  logic [FLAGS_W-1:0]  out_flags_r;
  logic [TIME_W-1:0]   out_last_r;

  // Write port and result of the commit decision.
  logic                wr_valid_en;
  logic                wr_valid_bit;
  logic                wr_data_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [BYTES_W-1:0]  wr_bytes;
  logic [PKTS_W-1:0]   wr_pkts;
  logic [FLAGS_W-1:0]  wr_flags;
  status_t             res_status;
  logic [BYTES_W-1:0]  res_bytes;
  logic [PKTS_W-1:0]   res_pkts;
  logic [FLAGS_W-1:0]  res_flags;
  logic [TIME_W-1:0]   res_last;

  // Scan issues one read per cycle and compares the slot read in the cycle before.
  assign issue    = cmd.scan_en && !hit_r && (cnt_r != CNT_END);
  assign hit_now  = cmp_vld_r && !hit_r && rd_valid_q && (rd_key_q == req_key_r);
  assign free_now = cmp_vld_r && !rd_valid_q && !free_found_r;

  always_comb begin
    cnt_nxt        = cnt_r;
    hit_nxt        = hit_r;
    free_found_nxt = free_found_r;
    cmp_vld_nxt    = issue;
    if (cmd.accept) begin
      cnt_nxt        = '0;
      hit_nxt        = 1'b0;
      free_found_nxt = 1'b0;
    end else begin
      if (cmd.clear_en || issue) cnt_nxt = cnt_r + CNT_W'(1);
      if (hit_now) hit_nxt = 1'b1;
      if (free_now) free_found_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
    end
  end

  // Payload registers of the scan: request, compared index, matching slot.
  always_ff @(posedge clk) begin
    cmp_idx_r <= cnt_r[IDX_W-1:0];
    if (cmd.accept) begin
      req_type_r  <= in_req_type;
      req_key_r   <= in_flow_key[KEY_BITS-1:0];
      req_bytes_r <= in_add_bytes;
      req_pkts_r  <= in_add_packets;
      req_flags_r <= in_tcp_flag_bits;
      req_time_r  <= in_seen_time;
    end
    if (hit_now) begin
      hit_idx_r   <= cmp_idx_r;
      hit_bytes_r <= rd_bytes_q;
      hit_pkts_r  <= rd_pkts_q;
      hit_flags_r <= rd_flags_q;
      hit_last_r  <= rd_last_q;
    end
    if (free_now) free_idx_r <= cmp_idx_r;
  end

  // Clearing writes and commit decision: update, add, remove, miss or full.
  always_comb begin
    wr_valid_en  = 1'b0;
    wr_valid_bit = 1'b0;
    wr_data_en   = 1'b0;
    wr_addr      = cnt_r[IDX_W-1:0];
    wr_bytes     = req_bytes_r;
    wr_pkts      = req_pkts_r;
    wr_flags     = req_flags_r;
    res_status   = ST_NOT_FOUND;
    res_bytes    = '0;
    res_pkts     = '0;
    res_flags    = '0;
    res_last     = '0;
    if (cmd.clear_en) begin
      wr_valid_en = 1'b1;
    end else if (cmd.commit) begin
      priority if (req_type_r == REQ_REMOVE && hit_r) begin
        wr_valid_en = 1'b1;
        wr_addr     = hit_idx_r;
        res_status  = ST_REMOVED;
        res_bytes   = hit_bytes_r;
        res_pkts    = hit_pkts_r;
        res_flags   = hit_flags_r;
        res_last    = hit_last_r;
      end else if (req_type_r == REQ_REMOVE) begin
        res_status = ST_NOT_FOUND;
      end else if (hit_r) begin
        wr_valid_en  = 1'b1;
        wr_valid_bit = 1'b1;
        wr_data_en   = 1'b1;
        wr_addr      = hit_idx_r;
        wr_bytes     = hit_bytes_r + req_bytes_r;
        wr_pkts      = hit_pkts_r + req_pkts_r;
        wr_flags     = hit_flags_r | req_flags_r;
        res_status   = ST_UPDATED;
        res_bytes    = wr_bytes;
        res_pkts     = wr_pkts;
        res_flags    = wr_flags;
        res_last     = req_time_r;
      end else if (free_found_r) begin
        wr_valid_en  = 1'b1;
        wr_valid_bit = 1'b1;
        wr_data_en   = 1'b1;
        wr_addr      = free_idx_r;
        res_status   = ST_ADDED;
        res_bytes    = req_bytes_r;
        res_pkts     = req_pkts_r;
        res_flags    = req_flags_r;
        res_last     = req_time_r;
      end else begin
        res_status = ST_FULL;
      end
    end
  end

  // Slot memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (wr_valid_en) mem_valid[wr_addr] <= wr_valid_bit;
    if (wr_data_en) begin
      mem_key[wr_addr]   <= req_key_r;
      mem_bytes[wr_addr] <= wr_bytes;
      mem_pkts[wr_addr]  <= wr_pkts;
      mem_flags[wr_addr] <= wr_flags;
      mem_last[wr_addr]  <= req_time_r;
    end
    rd_valid_q <= mem_valid[cnt_r[IDX_W-1:0]];
    rd_key_q   <= mem_key[cnt_r[IDX_W-1:0]];
    rd_bytes_q <= mem_bytes[cnt_r[IDX_W-1:0]];
    rd_pkts_q  <= mem_pkts[cnt_r[IDX_W-1:0]];
    rd_flags_q <= mem_flags[cnt_r[IDX_W-1:0]];
    rd_last_q  <= mem_last[cnt_r[IDX_W-1:0]];
  end

  // Result register: filled on commit, emptied when the transaction is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_bytes_r  <= res_bytes;
      out_pkts_r   <= res_pkts;
      out_flags_r  <= res_flags;
      out_last_r   <= res_last;
    end
  end

  // Status to the controller.
  always_comb begin
    sts.clear_last = (cnt_r == CNT_LAST);
    sts.scan_done  = hit_r || ((cnt_r == CNT_END) && !cmp_vld_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_total_bytes   = out_bytes_r;
  assign out_total_packets = out_pkts_r;
  assign out_flags_seen    = out_flags_r;
  assign out_last_seen     = out_last_r;

endmodule

`default_nettype wire

@@ hdl/flow_record_table.sv @@
// Top level of the flow record table: controller, datapath and checks.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    req_type, flow_key, add_bytes, add_packets,
//                                            tcp_flag_bits, seen_time
//   out_     output     out_valid/out_stall  status, total_bytes, total_packets,
//                                            flags_seen, last_seen
//
// One request is handled at a time. The scan reads one slot per cycle from the slot
// memories and ends at the first slot whose key matches; a miss (add of a new key,
// remove of an absent key) scans every slot. The next request can be accepted as
// the result appears. After reset a clearing pass resets the slot valid bits; no
// request is accepted until it ends.
// The result register lets a finished transaction wait under out_stall; the next
// request is accepted meanwhile and its commit waits until the register is free.
`default_nettype none

module flow_record_table
  import frt_pkg::*;
#(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 64
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  in_req_type,
  input  wire  [KEY_IN_W-1:0]  in_flow_key,
  input  wire  [BYTES_W-1:0]   in_add_bytes,
  input  wire  [PKTS_W-1:0]    in_add_packets,
  input  wire  [FLAGS_W-1:0]   in_tcp_flag_bits,
  input  wire  [TIME_W-1:0]    in_seen_time,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [BYTES_W-1:0]   out_total_bytes,
  output logic [PKTS_W-1:0]    out_total_packets,
  output logic [FLAGS_W-1:0]   out_flags_seen,
  output logic [TIME_W-1:0]    out_last_seen
);

  cmd_t cmd;
  sts_t sts;
  logic idle;

  frt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  frt_dpath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_flow_key       (in_flow_key),
    .in_add_bytes      (in_add_bytes),
    .in_add_packets    (in_add_packets),
    .in_tcp_flag_bits  (in_tcp_flag_bits),
    .in_seen_time      (in_seen_time),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_total_bytes   (out_total_bytes),
    .out_total_packets (out_total_packets),
    .out_flags_seen    (out_flags_seen),
    .out_last_seen     (out_last_seen)
  );

  // Requests are taken only while the controller waits for one.
  assign in_stall = !idle;

`ifndef NO_ASSERTIONS
  // A commit never overwrites a result that is still stalled.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("commit while the result register is occupied");

  // An accepted transaction makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting a transaction");

  // Misses and drops carry all-zero totals.
  a_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_NOT_FOUND || out_status == ST_FULL)) |->
    (out_total_bytes == '0 && out_total_packets == '0 &&
     out_flags_seen == '0 && out_last_seen == '0))
    else $error("nonzero totals on a miss or drop");

  // No two controller commands (clear, accept, scan, commit) are issued together.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_en, cmd.accept, cmd.scan_en, cmd.commit}))
    else $error("controller issued overlapping commands");
`endif

endmodule

`default_nettype wire
